@@ hw/rtl/bcsh_pkg.sv @@
package bcsh_pkg;

  localparam int NUM_BINS   = 120;
  localparam int GROUP_SIZE = 8;
  localparam int CELLS      = NUM_BINS * GROUP_SIZE;

  localparam int BIN_W   = 7;
  localparam int CODE_W  = $clog2(GROUP_SIZE);
  localparam int ADDR_W  = BIN_W + CODE_W;
  localparam int COL_W   = 5;
  localparam int CNT_W   = 64;
  localparam int REC_W   = 32;
  localparam int WORD_W  = 24;
  localparam int TRIG_W  = 17;

  localparam logic CMD_ACCUM   = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(3 * GROUP_SIZE);

  localparam logic [1:0] GRP_A   = 2'd0;
  localparam logic [1:0] GRP_B   = 2'd1;
  localparam logic [1:0] GRP_C   = 2'd2;
  localparam logic [1:0] GRP_TOT = 2'd3;

  function automatic logic [CODE_W-1:0] code_a(input logic [TRIG_W-1:0] t);
    code_a = {t[16], t[11:10]};
  endfunction

  function automatic logic [CODE_W-1:0] code_b(input logic [TRIG_W-1:0] t);
    code_b = {t[15], t[9:8]};
  endfunction

  function automatic logic [CODE_W-1:0] code_c(input logic [TRIG_W-1:0] t);
    code_c = {t[14], 2'b00};
  endfunction

endpackage

@@ hw/rtl/bunch_crossing_scaler_histogram_unit.sv @@
// Accumulate transactions: one per cycle while idle, read-modify-write with
//   forwarding of the previous write into the next read of the same counter.
// Readout transaction: 25 results, each a registered RAM read then output register;
//   the next waits until the last is taken; input stalls for the whole run.
// Reset: a clearing pass over all 960 cells zeroes every counter, input stalled.
module bunch_crossing_scaler_histogram_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [bcsh_pkg::REC_W-1:0]   record_number_i,
  input  logic [bcsh_pkg::WORD_W-1:0]  channel_word_i,
  input  logic [bcsh_pkg::CNT_W-1:0]   count_value_i,
  input  logic [bcsh_pkg::BIN_W-1:0]   read_bin_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bcsh_pkg::BIN_W-1:0]   bin_index_o,
  output logic [bcsh_pkg::COL_W-1:0]   column_o,
  output logic [bcsh_pkg::CNT_W-1:0]   count_o,
  output logic                         last_o
);
  import bcsh_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SHOW
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] sweep_q;
  logic [BIN_W-1:0]  rbin_q;
  logic [COL_W-1:0]  col_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_addr_a_q, s1_addr_b_q, s1_addr_c_q;
  logic [BIN_W-1:0]  s1_bin_q;
  logic [CNT_W-1:0]  s1_value_q;

  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_a_q, fwd_addr_b_q, fwd_addr_c_q;
  logic [BIN_W-1:0]  fwd_bin_q;
  logic [CNT_W-1:0]  fwd_a_q, fwd_b_q, fwd_c_q, fwd_t_q;

  logic              in_accept;
  logic              clearing;
  logic              header;
  logic [BIN_W-1:0]  in_bin;
  logic [TRIG_W-1:0] trig;
  logic              acc_ok;
  logic              rd_ok;
  logic              out_accept;
  logic [COL_W-1:0]  rd_col;

  logic [ADDR_W-1:0] raddr_a, raddr_b, raddr_c;
  logic [BIN_W-1:0]  raddr_t;
  logic [CNT_W-1:0]  rdata_a, rdata_b, rdata_c, rdata_t;
  logic [CNT_W-1:0]  old_a, old_b, old_c, old_t;
  logic [CNT_W-1:0]  sum_a, sum_b, sum_c, sum_t;

  logic              we;
  logic [ADDR_W-1:0] waddr_a, waddr_b, waddr_c;
  logic [BIN_W-1:0]  waddr_t;
  logic [CNT_W-1:0]  wdata_a, wdata_b, wdata_c, wdata_t;
  logic [CNT_W-1:0]  rd_sel;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign clearing   = (state_q == ST_CLEAR);
  assign out_accept = out_valid_q && !out_stall_i;

  assign in_bin = channel_word_i[WORD_W-1:TRIG_W];
  assign trig   = channel_word_i[TRIG_W-1:0];
  assign header = (record_number_i == REC_W'(1)) && (channel_word_i == '0);
  assign acc_ok = in_accept && (command_i == CMD_ACCUM) && !header
               && ({1'b0, in_bin} < (BIN_W + 1)'(NUM_BINS));
  assign rd_ok  = in_accept && (command_i == CMD_READOUT)
               && ({1'b0, read_bin_i} < (BIN_W + 1)'(NUM_BINS));

  assign rd_col = (state_q == ST_SHOW) ? col_q + COL_W'(1) : col_q;

  always_comb begin
    if (state_q == ST_IDLE) begin
      raddr_a = {in_bin, code_a(trig)};
      raddr_b = {in_bin, code_b(trig)};
      raddr_c = {in_bin, code_c(trig)};
      raddr_t = in_bin;
    end else begin
      raddr_a = {rbin_q, rd_col[CODE_W-1:0]};
      raddr_b = {rbin_q, rd_col[CODE_W-1:0]};
      raddr_c = {rbin_q, rd_col[CODE_W-1:0]};
      raddr_t = rbin_q;
    end
  end

  // previous cycle's write is not yet visible in this cycle's read data
  assign old_a = (fwd_valid_q && fwd_addr_a_q == s1_addr_a_q) ? fwd_a_q : rdata_a;
  assign old_b = (fwd_valid_q && fwd_addr_b_q == s1_addr_b_q) ? fwd_b_q : rdata_b;
  assign old_c = (fwd_valid_q && fwd_addr_c_q == s1_addr_c_q) ? fwd_c_q : rdata_c;
  assign old_t = (fwd_valid_q && fwd_bin_q == s1_bin_q) ? fwd_t_q : rdata_t;

  assign sum_a = old_a + s1_value_q;
  assign sum_b = old_b + s1_value_q;
  assign sum_c = old_c + s1_value_q;
  assign sum_t = old_t + s1_value_q;

  assign we      = clearing || s1_valid_q;
  assign waddr_a = clearing ? sweep_q : s1_addr_a_q;
  assign waddr_b = clearing ? sweep_q : s1_addr_b_q;
  assign waddr_c = clearing ? sweep_q : s1_addr_c_q;
  assign waddr_t = clearing ? sweep_q[ADDR_W-1:CODE_W] : s1_bin_q;
  assign wdata_a = clearing ? '0 : sum_a;
  assign wdata_b = clearing ? '0 : sum_b;
  assign wdata_c = clearing ? '0 : sum_c;
  assign wdata_t = clearing ? '0 : sum_t;

  always_comb begin
    case (col_q[COL_W-1:CODE_W])
      GRP_A:   rd_sel = rdata_a;
      GRP_B:   rd_sel = rdata_b;
      GRP_C:   rd_sel = rdata_c;
      GRP_TOT: rd_sel = rdata_t;
      default: rd_sel = rdata_t;
    endcase
  end

  bcsh_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr_a), .wdata_i(wdata_a),
    .raddr_i(raddr_a), .rdata_o(rdata_a)
  );

  bcsh_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr_b), .wdata_i(wdata_b),
    .raddr_i(raddr_b), .rdata_o(rdata_b)
  );

  bcsh_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_ram_c (
    .clk_i, .we_i(we), .waddr_i(waddr_c), .wdata_i(wdata_c),
    .raddr_i(raddr_c), .rdata_o(rdata_c)
  );

  bcsh_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_ram_tot (
    .clk_i, .we_i(we), .waddr_i(waddr_t), .wdata_i(wdata_t),
    .raddr_i(raddr_t), .rdata_o(rdata_t)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc_ok;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_ok) begin
      s1_addr_a_q <= raddr_a;
      s1_addr_b_q <= raddr_b;
      s1_addr_c_q <= raddr_c;
      s1_bin_q    <= in_bin;
      s1_value_q  <= count_value_i;
    end
    if (s1_valid_q) begin
      fwd_addr_a_q <= s1_addr_a_q;
      fwd_addr_b_q <= s1_addr_b_q;
      fwd_addr_c_q <= s1_addr_c_q;
      fwd_bin_q    <= s1_bin_q;
      fwd_a_q      <= sum_a;
      fwd_b_q      <= sum_b;
      fwd_c_q      <= sum_c;
      fwd_t_q      <= sum_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      rbin_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          sweep_q <= sweep_q + ADDR_W'(1);
          if (sweep_q == ADDR_W'(CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (rd_ok) begin
            rbin_q  <= read_bin_i;
            col_q   <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          out_count_q <= rd_sel;
          out_valid_q <= 1'b1;
          state_q     <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_accept) begin
            out_valid_q <= 1'b0;
            if (col_q == LAST_COL) begin
              state_q <= ST_IDLE;
            end else begin
              col_q   <= rd_col;
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = rbin_q;
  assign column_o    = col_q;
  assign count_o     = out_count_q;
  assign last_o      = (col_q == LAST_COL);

  a_out_only_in_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_SHOW)
    else $error("result shown outside readout");

  a_no_update_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_valid_q)
    else $error("counter update during clearing pass");

  a_update_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_ok |=> s1_valid_q && $past(state_q == ST_IDLE))
    else $error("accumulate not staged");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && last_o |=> state_q == ST_IDLE && !out_valid_q)
    else $error("readout did not end after total");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> col_q <= LAST_COL)
    else $error("column out of range");

endmodule

@@ hw/rtl/bcsh_ram.sv @@
module bcsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 960
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/scaler_histogram_checker.sv @@
`timescale 1ns / 100ps

module scaler_histogram_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        command_i,
  input  logic [bcsh_pkg::REC_W-1:0]  record_number_i,
  input  logic [bcsh_pkg::WORD_W-1:0] channel_word_i,
  input  logic [bcsh_pkg::CNT_W-1:0]  count_value_i,
  input  logic [bcsh_pkg::BIN_W-1:0]  read_bin_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [bcsh_pkg::BIN_W-1:0]  bin_index_i,
  input  logic [bcsh_pkg::COL_W-1:0]  column_i,
  input  logic [bcsh_pkg::CNT_W-1:0]  count_i,
  input  logic                        last_i,
  output int                          mismatch_count_o,
  output int                          pending_count_o
);
  import bcsh_pkg::*;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [COL_W-1:0] column;
    logic [CNT_W-1:0] count;
    logic             last;
  } bin_readout_t;

  logic [CNT_W-1:0] hist_a [NUM_BINS][GROUP_SIZE];
  logic [CNT_W-1:0] hist_b [NUM_BINS][GROUP_SIZE];
  logic [CNT_W-1:0] hist_c [NUM_BINS][GROUP_SIZE];
  logic [CNT_W-1:0] hist_total [NUM_BINS];
  bin_readout_t     readout_queue [$];

  task automatic accumulate_record(input logic [REC_W-1:0] num,
                                   input logic [WORD_W-1:0] word,
                                   input logic [CNT_W-1:0] value);
    logic [BIN_W-1:0]  bin;
    logic [TRIG_W-1:0] trig;
    logic [2:0]        ca;
    logic [2:0]        cb;
    logic [2:0]        cc;
    bin  = word[WORD_W-1:TRIG_W];
    trig = word[TRIG_W-1:0];
    ca   = 3'(((trig >> 10) & 3) | ((trig >> 14) & 4));
    cb   = 3'(((trig >> 8) & 3) | ((trig >> 13) & 4));
    cc   = 3'((trig >> 12) & 4);
    // header record and out-of-range bins leave the histogram untouched
    if (!(num == 1 && word == 0) && bin < NUM_BINS) begin
      hist_a[bin][ca] = hist_a[bin][ca] + value;
      hist_b[bin][cb] = hist_b[bin][cb] + value;
      hist_c[bin][cc] = hist_c[bin][cc] + value;
      hist_total[bin] = hist_total[bin] + value;
    end
  endtask

  task automatic queue_bin_readout(input logic [BIN_W-1:0] bin);
    bin_readout_t r;
    if (bin < NUM_BINS) begin
      for (int d = 0; d < GROUP_SIZE; d++) begin
        r = '{bin, COL_W'(d), hist_a[bin][d], 1'b0};
        readout_queue.push_back(r);
      end
      for (int d = 0; d < GROUP_SIZE; d++) begin
        r = '{bin, COL_W'(GROUP_SIZE + d), hist_b[bin][d], 1'b0};
        readout_queue.push_back(r);
      end
      for (int d = 0; d < GROUP_SIZE; d++) begin
        r = '{bin, COL_W'(2 * GROUP_SIZE + d), hist_c[bin][d], 1'b0};
        readout_queue.push_back(r);
      end
      r = '{bin, LAST_COL, hist_total[bin], 1'b1};
      readout_queue.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_readout_t exp_r;
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        for (int d = 0; d < GROUP_SIZE; d++) begin
          hist_a[b][d] = '0;
          hist_b[b][d] = '0;
          hist_c[b][d] = '0;
        end
        hist_total[b] = '0;
      end
      readout_queue.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (readout_queue.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, %s %0d col %0d count %h last %0d",
                   $time, "actual bin", bin_index_i, column_i, count_i, last_i);
          mismatch_count_o++;
        end else begin
          exp_r = readout_queue.pop_front();
          if (bin_index_i !== exp_r.bin) begin
            $display("%0t: bin_index expected %0d actual %0d", $time, exp_r.bin, bin_index_i);
            mismatch_count_o++;
          end
          if (column_i !== exp_r.column) begin
            $display("%0t: column expected %0d actual %0d", $time, exp_r.column, column_i);
            mismatch_count_o++;
          end
          if (count_i !== exp_r.count) begin
            $display("%0t: count expected %h actual %h", $time, exp_r.count, count_i);
            mismatch_count_o++;
          end
          if (last_i !== exp_r.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_r.last, last_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_READOUT) begin
          queue_bin_readout(read_bin_i);
        end else begin
          accumulate_record(record_number_i, channel_word_i, count_value_i);
        end
      end
      pending_count_o = readout_queue.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import bcsh_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 120;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              command = CMD_ACCUM;
  logic [REC_W-1:0]  record_number = '0;
  logic [WORD_W-1:0] channel_word = '0;
  logic [CNT_W-1:0]  count_value = '0;
  logic [BIN_W-1:0]  read_bin = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BIN_W-1:0]  bin_index;
  logic [COL_W-1:0]  column;
  logic [CNT_W-1:0]  count;
  logic              last;
  int                mismatches;
  int                pending;
  int                send_idle_pct = 14;
  int                recv_idle_pct = 65;
  int                quiet_cycles = 0;

  always #10 clk = ~clk;

  bunch_crossing_scaler_histogram_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .record_number_i(record_number),
    .channel_word_i (channel_word),
    .count_value_i  (count_value),
    .read_bin_i     (read_bin),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .bin_index_o    (bin_index),
    .column_o       (column),
    .count_o        (count),
    .last_o         (last)
  );

  scaler_histogram_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .record_number_i(record_number),
    .channel_word_i (channel_word),
    .count_value_i  (count_value),
    .read_bin_i     (read_bin),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .bin_index_i    (bin_index),
    .column_i       (column),
    .count_i        (count),
    .last_i         (last),
    .mismatch_count_o(mismatches),
    .pending_count_o(pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic cmd, input logic [REC_W-1:0] num,
                      input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] value,
                      input logic [BIN_W-1:0] rbin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    record_number <= num;
    channel_word  <= word;
    count_value   <= value;
    read_bin      <= rbin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [BIN_W-1:0] pick_bin();
    case ($urandom_range(0, 19))
      0:       pick_bin = BIN_W'($urandom_range(NUM_BINS, 127));
      1, 2:    pick_bin = BIN_W'($urandom_range(0, NUM_BINS - 1));
      3, 4, 5,
      6, 7, 8: pick_bin = BIN_W'($urandom_range(112, NUM_BINS - 1));
      default: pick_bin = BIN_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic random_item();
    logic [BIN_W-1:0]  bin;
    logic [REC_W-1:0]  num;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  value;
    bin = pick_bin();
    num = $urandom;
    case ($urandom_range(0, 3))
      0:       value = CNT_W'($urandom_range(0, 15));
      1:       value = {32'hFFFF_FFFF, 28'hFFF_FFFF, 4'($urandom)};
      default: value = {$urandom, $urandom};
    endcase
    word = {bin, TRIG_W'($urandom)};
    if ($urandom_range(0, 29) == 0) begin
      num  = 1;
      word = '0;
    end
    if ($urandom_range(0, 4) == 0) begin
      send(CMD_READOUT, num, word, value, bin);
    end else begin
      send(CMD_ACCUM, num, word, value, BIN_W'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(CMD_READOUT, '0, '0, '0, 7'd0);
    send(CMD_READOUT, '1, '1, '1, 7'd119);
    send(CMD_READOUT, '0, '0, '0, 7'd127);
    send(CMD_READOUT, '0, '0, '0, 7'd120);
    send(CMD_ACCUM, 32'd1, 24'd0, '1, 7'd0);
    send(CMD_READOUT, '0, '0, '0, 7'd0);
    send(CMD_ACCUM, 32'd0, 24'd0, 64'd5, '1);
    send(CMD_ACCUM, 32'd1, 24'd1, 64'd3, 7'd0);
    send(CMD_ACCUM, '1, {7'd119, 17'h1FFFF}, '1, 7'd0);
    send(CMD_ACCUM, '1, {7'd119, 17'h1FFFF}, 64'd2, 7'd0);
    send(CMD_ACCUM, 32'd7, {7'd120, 17'h1CF00}, 64'd9, 7'd3);
    send(CMD_ACCUM, 32'd8, 24'hFFFFFF, 64'd9, 7'd3);
    send(CMD_ACCUM, 32'd9, {7'd3, 17'h1CF00}, 64'd100, 7'd0);
    send(CMD_ACCUM, 32'd10, {7'd3, 17'h00400}, 64'd1, 7'd0);
    send(CMD_ACCUM, 32'd11, {7'd3, 17'h00200}, 64'd2, 7'd0);
    send(CMD_ACCUM, 32'd12, {7'd3, 17'h10000}, 64'd4, 7'd0);
    send(CMD_ACCUM, 32'd13, {7'd3, 17'h030FF}, 64'h8000_0000_0000_0000, 7'd0);
    send(CMD_READOUT, '1, '1, '1, 7'd0);
    send(CMD_READOUT, '0, '0, '0, 7'd3);
    send(CMD_READOUT, '1, 24'hAAAAAA, '0, 7'd119);
    // hold off until the whole readout has drained
    drain();

    for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    drain();
    send_idle_pct = 65;
    recv_idle_pct = 14;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    for (int b = 0; b < 8; b++) send(CMD_READOUT, '0, '0, '0, BIN_W'(b));
    drain();
    repeat (60) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
